/* hdl/sidec_pkg.sv */
// Shared types and constants for the signed integer to decimal text unit.
package sidec_pkg;

	localparam int NumDigits = 10;
	localparam int DigitW    = 4;
	localparam int MagW      = 32;
	localparam int CharW     = 6;
	localparam int CntW      = 4;

	localparam logic [CharW-1:0] CharMinus = 6'd45;
	localparam logic [CharW-1:0] CharZero  = 6'd48;

	typedef logic [DigitW-1:0] digit_t;
	typedef digit_t [NumDigits-1:0] digit_vec_t;

	// One converted number on its way to the serializer.
	typedef struct packed {
		logic       neg;
		digit_vec_t digits;  // index 0 is the least significant digit
		logic [CntW-1:0] ndig;
	} conv_word_t;

endpackage

/* hdl/signed_int_to_decimal_ascii_unit.sv */
// Top level of the signed integer to decimal text unit.
// Usage:
//   The input channel (in_valid/in_ready/value) takes one signed 32-bit
//   word per handshake. The output channel (out_valid/out_ready) sends the
//   decimal text of that word, one character per word on char_code, with a
//   leading minus for negative values and last_char high on the final digit.
//   Path from the input handshake to the first character: magnitude stage,
//   ten digit stages, serializer load. A number gives one character per digit
//   plus a minus sign, 1 to 11 in all. The serializer emits one character
//   per cycle while out_ready is high and loads the next number with its
//   last character; the digit pipeline keeps further numbers queued behind it.
//   Reset clears all valid bits; no output word is pending after reset.
//   When the receiver stalls, the current character holds and the pipeline
//   fills and then drops in_ready; nothing is lost or repeated.
module signed_int_to_decimal_ascii_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  char_code,
	output logic        last_char
);

	logic                  mid_valid;
	logic                  mid_ready;
	sidec_pkg::conv_word_t mid_word;

	sidec_digit_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_word  (mid_word)
	);

	sidec_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_word   (mid_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last_char (last_char)
	);

`ifndef NO_ASSERTIONS
	// A stalled character must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_char))
		else $error("output word changed while stalled");

	// Codes are only minus or digits.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code == sidec_pkg::CharMinus && !last_char) ||
			(char_code >= sidec_pkg::CharZero && char_code <= sidec_pkg::CharZero + 6'd9))
		else $error("bad character code");

	// After a minus sign comes a digit.
	a_sign_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && char_code == sidec_pkg::CharMinus
		|=> out_valid && char_code != sidec_pkg::CharMinus)
		else $error("minus sign not followed by a digit");
`endif

endmodule

/* hdl/sidec_digit_pipe.sv */
// Pipeline that peels decimal digits off a magnitude, one digit per stage.
module sidec_digit_pipe (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [31:0]                value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output sidec_pkg::conv_word_t      out_word
);

	localparam int Stages = sidec_pkg::NumDigits;
	// ceil(2^35 / 10): (m * Recip10) >> 35 is m / 10 for any 32-bit m.
	localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

	logic                          vld_s   [Stages+1];
	logic                          neg_s   [Stages+1];
	logic [sidec_pkg::MagW-1:0]    mag_s   [Stages+1];
	sidec_pkg::digit_vec_t         dig_s   [Stages+1];
	logic                          adv     [Stages+1];

	// Stage 0: magnitude. The most negative value gives 2^31, which fits 32 bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0] && in_valid) begin
			neg_s[0] <= value[31];
			mag_s[0] <= value[31] ? (~value + 32'd1) : value;
			dig_s[0] <= '0;
		end
	end

	assign in_ready = adv[0];

	for (genvar s = 1; s <= Stages; s++) begin : g_stage
		logic [63:0]                prod;
		logic [31:0]                quo;
		logic [31:0]                rem;
		sidec_pkg::digit_vec_t      d;
		always_comb begin
			prod = {32'd0, mag_s[s-1]} * {32'd0, Recip10};
			quo  = {3'b000, prod[63:35]};
			rem  = mag_s[s-1] - {quo[28:0], 3'b000} - {quo[30:0], 1'b0};
			d    = dig_s[s-1];
			d[s-1] = sidec_pkg::DigitW'(rem);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (adv[s]) begin
				vld_s[s] <= vld_s[s-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[s] && vld_s[s-1]) begin
				neg_s[s] <= neg_s[s-1];
				mag_s[s] <= quo;
				dig_s[s] <= d;
			end
		end
	end

	// A stage advances when it is empty or the next one advances.
	always_comb begin
		adv[Stages] = out_ready || !vld_s[Stages];
		for (int s = Stages - 1; s >= 0; s--) begin
			adv[s] = adv[s+1] || !vld_s[s];
		end
	end

	// Count significant digits; at least one.
	logic [sidec_pkg::CntW-1:0] ndig;
	always_comb begin
		ndig = sidec_pkg::CntW'(1);
		for (int k = 1; k < sidec_pkg::NumDigits; k++) begin
			if (dig_s[Stages][k] != '0) begin
				ndig = sidec_pkg::CntW'(k + 1);
			end
		end
	end

	assign out_valid       = vld_s[Stages];
	assign out_word.neg    = neg_s[Stages];
	assign out_word.digits = dig_s[Stages];
	assign out_word.ndig   = ndig;

endmodule

/* hdl/sidec_serializer.sv */
// Serializer that sends a converted number out one character per word.
module sidec_serializer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  sidec_pkg::conv_word_t          in_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sidec_pkg::CharW-1:0]    char_code,
	output logic                           last_char
);

	logic                        busy_q;
	logic                        sign_q;
	sidec_pkg::digit_vec_t       dig_q;
	logic [sidec_pkg::CntW-1:0]  idx_q;   // digit to send next, plus one

	logic fire;
	assign fire     = busy_q && out_ready;
	assign in_ready = !busy_q || (fire && !sign_q && idx_q == sidec_pkg::CntW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
		end else if (fire && !sign_q && idx_q == sidec_pkg::CntW'(1)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sign_q <= in_word.neg;
			dig_q  <= in_word.digits;
			idx_q  <= in_word.ndig;
		end else if (fire) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				idx_q <= idx_q - sidec_pkg::CntW'(1);
			end
		end
	end

	logic [sidec_pkg::CntW-1:0] sel;
	assign sel       = idx_q - sidec_pkg::CntW'(1);
	assign out_valid = busy_q;
	assign char_code = sign_q ? sidec_pkg::CharMinus
		: sidec_pkg::CharZero + sidec_pkg::CharW'(dig_q[sel]);
	assign last_char = !sign_q && idx_q == sidec_pkg::CntW'(1);

endmodule
